/* sv/ble_pkg.sv */
package ble_pkg;

   // longest encoding: header plus eight length bytes
   localparam logic [3:0] MAX_BYTES = 4'd9;
   // automatic sizing choices
   localparam logic [3:0] AUTO_SMALL = 4'd4;
   localparam logic [3:0] AUTO_MID   = 4'd8;
   localparam logic [3:0] AUTO_FULL  = 4'd9;
   // long form header base
   localparam logic [7:0] LONG_HEADER = 8'h80;

   typedef struct packed {
      logic [63:0] length_value;
      logic [3:0]  requested_size;
      logic [3:0]  buffer_limit;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic [3:0] total_bytes;
      logic       size_saturated;
      logic       size_overridden;
      logic       buffer_truncated;
   } rsp_type;

   // sizing decision for one item
   typedef struct packed {
      logic [63:0] length_value;
      logic [3:0]  total_bytes;
      logic        size_saturated;
      logic        size_overridden;
      logic        buffer_truncated;
   } plan_type;

endpackage

/* sv/ble_size.sv */
module ble_size (
   input  ble_pkg::req_type  req,
   output ble_pkg::plan_type plan
);

   // true if the length fits in an encoding of s bytes
   function automatic logic fits_in(input logic [63:0] len, input logic [3:0] s);
      logic ok;
      case (s)
         4'd1: ok = (len[63:7] == '0);
         4'd2: ok = (len[63:8] == '0);
         4'd3: ok = (len[63:16] == '0);
         4'd4: ok = (len[63:24] == '0);
         4'd5: ok = (len[63:32] == '0);
         4'd6: ok = (len[63:40] == '0);
         4'd7: ok = (len[63:48] == '0);
         4'd8: ok = (len[63:56] == '0);
         default: ok = 1'b1;
      endcase
      return ok;
   endfunction

   logic [3:0] sat_size;
   logic       sat;
   logic       ovr;
   logic [3:0] auto_size;
   logic [3:0] chosen;
   logic [3:0] lim;

   always_comb begin
      // saturate the request
      sat      = (req.requested_size > ble_pkg::MAX_BYTES);
      sat_size = sat ? ble_pkg::MAX_BYTES : req.requested_size;

      // override when the length does not fit
      ovr = (sat_size != 4'd0) && !fits_in(req.length_value, sat_size);

      // automatic sizing
      if (req.length_value[63:24] == '0) begin
         auto_size = ble_pkg::AUTO_SMALL;
      end else if (req.length_value[63:56] == '0) begin
         auto_size = ble_pkg::AUTO_MID;
      end else begin
         auto_size = ble_pkg::AUTO_FULL;
      end
      chosen = (ovr || sat_size == 4'd0) ? auto_size : sat_size;

      // buffer limit, zero taken as one and above nine as nine
      if (req.buffer_limit == 4'd0) begin
         lim = 4'd1;
      end else if (req.buffer_limit > ble_pkg::MAX_BYTES) begin
         lim = ble_pkg::MAX_BYTES;
      end else begin
         lim = req.buffer_limit;
      end

      plan.length_value     = req.length_value;
      plan.size_saturated   = sat;
      plan.size_overridden  = ovr;
      plan.buffer_truncated = (chosen > lim);
      plan.total_bytes      = (chosen > lim) ? lim : chosen;
   end

endmodule

/* sv/ber_length_encoder_top.sv */
// BER definite-length encoder
//
// Input channel: an item (length, requested size, buffer limit) is taken
// at a rising edge where start is high and busy is low. Sizing is done in
// the same cycle and the plan is stored in a work register.
// Result channel: one encoded byte per cycle, marked by rsp_valid for
// exactly one cycle; header first, then length bytes big-endian, with
// last_byte on the final one. An item gives 1 to 9 bytes.
// Latency: the first byte of an item passes through the work register and then
// the output register before it is on the result ports.
// Throughput: one byte per cycle; the byte counter steps through total_bytes
// positions of an item, and busy drops on the cycle of its last byte, so the
// next item follows without a gap.
// The receiver cannot stall: every byte is shown once and is gone.
// Reset (synchronous, active high) drops any item at work and any pending
// byte; busy is low in the cycle after reset.
module ber_length_encoder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ble_pkg::req_type req_data,
   output logic             rsp_valid,
   output ble_pkg::rsp_type rsp_data
);

   ble_pkg::plan_type plan;
   ble_pkg::plan_type work_plan_ff, work_plan_in;
   logic              work_valid_ff, work_valid_in;
   logic [3:0]        work_idx_ff, work_idx_in;
   logic              rsp_valid_ff;
   ble_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic              accept;
   logic              last_now;
   logic [2:0]        shift_idx;

   ble_size u_size (
      .req  (req_data),
      .plan (plan)
   );

   // byte counter control
   assign last_now = (work_idx_ff + 4'd1 == work_plan_ff.total_bytes);
   assign busy     = work_valid_ff && !last_now;
   assign accept   = start && !busy;

   always_comb begin
      work_plan_in  = work_plan_ff;
      work_idx_in   = work_idx_ff;
      work_valid_in = work_valid_ff;
      if (accept) begin
         work_plan_in  = plan;
         work_idx_in   = 4'd0;
         work_valid_in = 1'b1;
      end else if (work_valid_ff) begin
         if (last_now) begin
            work_valid_in = 1'b0;
         end else begin
            work_idx_in = work_idx_ff + 4'd1;
         end
      end
   end

   // byte selection for the current position
   always_comb begin
      shift_idx = 3'(work_plan_ff.total_bytes - 4'd1 - work_idx_ff);
      if (work_plan_ff.total_bytes == 4'd1) begin
         rsp_data_in.data_byte = work_plan_ff.length_value[7:0];
      end else if (work_idx_ff == 4'd0) begin
         rsp_data_in.data_byte = ble_pkg::LONG_HEADER
                               + {4'd0, work_plan_ff.total_bytes - 4'd1};
      end else begin
         rsp_data_in.data_byte = work_plan_ff.length_value[{shift_idx, 3'b000} +: 8];
      end
      rsp_data_in.last_byte        = last_now;
      rsp_data_in.total_bytes      = work_plan_ff.total_bytes;
      rsp_data_in.size_saturated   = work_plan_ff.size_saturated;
      rsp_data_in.size_overridden  = work_plan_ff.size_overridden;
      rsp_data_in.buffer_truncated = work_plan_ff.buffer_truncated;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= work_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_plan_ff <= work_plan_in;
      work_idx_ff  <= work_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a transfer produces its first byte after the work and output registers
   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid_ff)
      else $error("no byte after accepted transfer");

   // bytes of one encoding come without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.last_byte |=> rsp_valid_ff)
      else $error("gap inside an encoding");

   // size and truncation flag hold across one encoding
   a_stable_meta: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.last_byte |=>
         $stable(rsp_data_ff.total_bytes) && $stable(rsp_data_ff.buffer_truncated))
      else $error("encoding size changed mid-stream");

endmodule

/* tb/ber_length_encoder_top_tb.sv */
module ber_length_encoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 24;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   ble_pkg::req_type req_data = '0;
   logic             rsp_valid;
   ble_pkg::rsp_type rsp_data;

   // encoded bytes still to come, oldest first
   ble_pkg::rsp_type pending_bytes[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;

   ber_length_encoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // work out the byte sequence for one length and queue it
   task automatic predict_encoding(input ble_pkg::req_type item);
      int               sz;
      int               lim;
      logic             sat;
      logic             ovr;
      logic             trunc;
      logic             fits;
      ble_pkg::rsp_type enc;
      sz    = item.requested_size;
      sat   = 1'b0;
      ovr   = 1'b0;
      trunc = 1'b0;
      // oversized request saturates
      if (sz > ble_pkg::MAX_BYTES) begin
         sz  = ble_pkg::MAX_BYTES;
         sat = 1'b1;
      end
      // does the length fit the requested size
      if (sz == 1)
         fits = (item.length_value[63:7] == '0);
      else if (sz >= ble_pkg::MAX_BYTES || sz == 0)
         fits = 1'b1;
      else
         fits = ((item.length_value >> (8 * (sz - 1))) == 64'd0);
      if (sz != 0 && !fits) begin
         ovr = 1'b1;
         sz  = 0;
      end
      // automatic sizing
      if (sz == 0) begin
         if (item.length_value < 64'h0000_0000_0100_0000)
            sz = ble_pkg::AUTO_SMALL;
         else if (item.length_value < 64'h0100_0000_0000_0000)
            sz = ble_pkg::AUTO_MID;
         else
            sz = ble_pkg::AUTO_FULL;
      end
      // destination limit, zero means one byte, above nine means nine
      lim = item.buffer_limit;
      if (lim == 0)
         lim = 1;
      if (lim > ble_pkg::MAX_BYTES)
         lim = ble_pkg::MAX_BYTES;
      if (sz > lim) begin
         sz    = lim;
         trunc = 1'b1;
      end
      for (int k = 0; k < sz; k++) begin
         if (sz == 1)
            enc.data_byte = item.length_value[7:0];
         else if (k == 0)
            enc.data_byte = ble_pkg::LONG_HEADER + 8'(sz - 1);
         else
            enc.data_byte = 8'(item.length_value >> (8 * (sz - 1 - k)));
         enc.last_byte        = (k + 1 == sz);
         enc.total_bytes      = 4'(sz);
         enc.size_saturated   = sat;
         enc.size_overridden  = ovr;
         enc.buffer_truncated = trunc;
         pending_bytes.push_back(enc);
      end
   endtask

   function automatic ble_pkg::req_type make_item(input logic [63:0] len,
                                                  input logic [3:0] req,
                                                  input logic [3:0] lim);
      ble_pkg::req_type item;
      item.length_value   = len;
      item.requested_size = req;
      item.buffer_limit   = lim;
      return item;
   endfunction

   // random idle cycles, then one command transfer
   task automatic send_item(input ble_pkg::req_type item, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do
         @(posedge clock);
      while (busy);
      predict_encoding(item);
   endtask

   // check every byte against the oldest expectation
   always @(posedge clock) begin
      ble_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: byte mismatch, expected %p, actual %p", $time, want, rsp_data);
               mismatch_count++;
            end
         end
      end
   end

   // short form edges and forced single byte
   task automatic test_short_form();
      send_item(make_item(64'd0, 4'd1, 4'd9), 0);
      send_item(make_item(64'd127, 4'd1, 4'd9), 0);
      send_item(make_item(64'd128, 4'd1, 4'd9), 0);
      send_item(make_item(64'hffff_ffff_ffff_ffff, 4'd1, 4'd9), 0);
   endtask

   // explicit sizes, saturation and override
   task automatic test_requested_sizes();
      send_item(make_item(64'd255, 4'd2, 4'd9), 0);
      send_item(make_item(64'd256, 4'd2, 4'd9), 0);
      send_item(make_item(64'h00ff_ffff_ffff_ffff, 4'd8, 4'd9), 0);
      send_item(make_item(64'h0100_0000_0000_0000, 4'd8, 4'd9), 0);
      send_item(make_item(64'd0, 4'd9, 4'd9), 0);
      send_item(make_item(64'd5, 4'd10, 4'd9), 0);
      send_item(make_item(64'hffff_ffff_ffff_ffff, 4'd15, 4'd9), 0);
   endtask

   // automatic sizing thresholds
   task automatic test_auto_sizing();
      send_item(make_item(64'd0, 4'd0, 4'd9), 0);
      send_item(make_item(64'h0000_0000_00ff_ffff, 4'd0, 4'd9), 0);
      send_item(make_item(64'h0000_0000_0100_0000, 4'd0, 4'd9), 0);
      send_item(make_item(64'h00ff_ffff_ffff_ffff, 4'd0, 4'd9), 0);
      send_item(make_item(64'h0100_0000_0000_0000, 4'd0, 4'd9), 0);
   endtask

   // clamping to the destination, including out-of-range limits
   task automatic test_buffer_limits();
      send_item(make_item(64'd300, 4'd0, 4'd1), 0);
      send_item(make_item(64'h0123_4567_89ab_cdef, 4'd0, 4'd3), 0);
      send_item(make_item(64'h0123_4567_89ab_cdef, 4'd9, 4'd0), 0);
      send_item(make_item(64'd100, 4'd1, 4'd0), 0);
      send_item(make_item(64'h8000_0000_0000_0001, 4'd0, 4'd15), 0);
      send_item(make_item(64'd77, 4'd3, 4'd12), 0);
   endtask

   // lengths spread over every byte count, with power of two boundaries
   function automatic logic [63:0] random_length();
      logic [63:0] len;
      int          sel;
      int          nbytes;
      len = {$urandom, $urandom};
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
         nbytes = $urandom_range(0, 8);
         if (nbytes < 8)
            len = len & ((64'd1 << (8 * nbytes)) - 64'd1);
      end else if (sel < 9) begin
         len = 64'd1 << $urandom_range(0, 63);
         if ($urandom_range(0, 1))
            len = len - 64'd1;
      end
      return len;
   endfunction

   task automatic test_random_traffic(input int count, input int idle_pct);
      logic [3:0] req;
      logic [3:0] lim;
      repeat (count) begin
         req = 4'($urandom_range(0, 15));
         lim = $urandom_range(0, 1) ? 4'd9 : 4'($urandom_range(0, 15));
         send_item(make_item(random_length(), req, lim), idle_pct);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_form();
      test_requested_sizes();
      test_auto_sizing();
      test_buffer_limits();
      test_random_traffic(170, 28);
      test_random_traffic(170, 48);
      test_random_traffic(170, 0);
      start <= 1'b0;

      // let the last encodings drain
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
